FILE: rtl/mbps_pkg.sv
// Shared constants and types for the masked byte pattern scanner.
// No dependencies; used by every module of the block.
package mbps_pkg;

  localparam int PATTERN_SLOTS = 32;
  localparam int LEN_W         = 6;
  localparam int ADDR_W        = 64;
  localparam int CFG_ADDR_W    = 6;
  localparam int CFG_DATA_W    = 64;
  localparam int REG_IDX_W     = 3;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_2  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_3  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MASK       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH     = 3'd5;

  // Window status handed to the compare stage.
  typedef struct packed {
    logic pending;  // newest window entry is an item not yet compared
    logic armed;    // window holds at least pattern-length bytes
  } win_stat_t;

endpackage

FILE: rtl/mbps_regs.sv
// Configuration registers (APB-style) and pattern alignment to window taps.
// Depends on mbps_pkg.
module mbps_regs #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output logic [PATTERN_MAX-1:0][7:0]          aln_pat,
  output logic [PATTERN_MAX-1:0]               aln_care,
  output logic [mbps_pkg::LEN_W-1:0]           len_m1
);
  import mbps_pkg::*;

  localparam int MAX_LEN = (PATTERN_MAX < PATTERN_SLOTS) ? PATTERN_MAX : PATTERN_SLOTS;

  logic [3:0][63:0]          pattern_word;
  logic [31:0]               compare_mask;
  logic [LEN_W-1:0]          pattern_length;
  logic [REG_IDX_W-1:0]      reg_idx;
  logic                      wr_en;
  logic [LEN_W-1:0]          eff_len;
  logic [LEN_W-1:0]          len_m1_next;
  logic [PATTERN_MAX-1:0][7:0] aln_pat_next;
  logic [PATTERN_MAX-1:0]    aln_care_next;
  logic [255:0]              pattern_bits;

  assign pready       = 1'b1;
  assign reg_idx      = paddr[CFG_ADDR_W-1:3];
  assign wr_en        = psel && penable && pwrite && pready;
  assign pattern_bits = pattern_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word   <= '0;
      compare_mask   <= '0;
      pattern_length <= LEN_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_0: pattern_word[0] <= pwdata;
        REG_PATTERN_1: pattern_word[1] <= pwdata;
        REG_PATTERN_2: pattern_word[2] <= pwdata;
        REG_PATTERN_3: pattern_word[3] <= pwdata;
        REG_MASK:      compare_mask    <= pwdata[31:0];
        REG_LENGTH:    pattern_length  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_0: prdata = pattern_word[0];
      REG_PATTERN_1: prdata = pattern_word[1];
      REG_PATTERN_2: prdata = pattern_word[2];
      REG_PATTERN_3: prdata = pattern_word[3];
      REG_MASK:      prdata = CFG_DATA_W'(compare_mask);
      REG_LENGTH:    prdata = CFG_DATA_W'(pattern_length);
      default:       prdata = '0;
    endcase
  end

  // Zero length acts as one; clamp to the window depth and the pattern slots.
  always_comb begin
    eff_len = (pattern_length == '0) ? LEN_W'(1) : pattern_length;
    if (eff_len > LEN_W'(MAX_LEN)) begin
      eff_len = LEN_W'(MAX_LEN);
    end
    len_m1_next = eff_len - LEN_W'(1);
  end

  // Tap j (0 newest) holds pattern position len-1-j.
  always_comb begin
    logic [LEN_W-1:0] pos;
    pos = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pos = len_m1_next - LEN_W'(j);
      if (LEN_W'(j) <= len_m1_next) begin
        aln_pat_next[j]  = pattern_bits[{pos[4:0], 3'b000} +: 8];
        aln_care_next[j] = compare_mask[pos[4:0]];
      end else begin
        aln_pat_next[j]  = '0;
        aln_care_next[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    aln_pat  <= aln_pat_next;
    aln_care <= aln_care_next;
    len_m1   <= len_m1_next;
  end

endmodule

FILE: rtl/mbps_window.sv
// Sliding byte/address window with fill count; it is the input register.
// Depends on mbps_pkg.
module mbps_window #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  scan_valid,
  output logic                                  scan_stall,
  input  logic [7:0]                            data_byte,
  input  logic [mbps_pkg::ADDR_W-1:0]           byte_address,
  input  logic                                  region_last,
  input  logic [mbps_pkg::LEN_W-1:0]            len_m1,
  input  logic                                  advance,
  output logic [PATTERN_MAX-1:0][7:0]           win_bytes,
  output logic [PATTERN_MAX-1:0][mbps_pkg::ADDR_W-1:0] win_addr,
  output mbps_pkg::win_stat_t                   stat
);
  import mbps_pkg::*;

  localparam int FW = $clog2(PATTERN_MAX + 1);

  logic          pending;
  logic          flush;     // previous transfer closed its region
  logic [FW-1:0] fill;
  logic          accept;

  assign scan_stall  = pending && !advance;
  assign accept      = scan_valid && !scan_stall;
  assign stat.pending = pending;
  assign stat.armed   = 8'(fill) > 8'(len_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      flush   <= 1'b0;
      fill    <= '0;
    end else begin
      if (accept) begin
        pending <= 1'b1;
        flush   <= region_last;
        if (flush) begin
          fill <= FW'(1);
        end else if (fill != FW'(PATTERN_MAX)) begin
          fill <= fill + FW'(1);
        end
      end else if (advance) begin
        pending <= 1'b0;
      end
    end
  end

  // Stale entries past the fill count are never compared, so no clearing.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = PATTERN_MAX - 1; i > 0; i--) begin
        win_bytes[i] <= win_bytes[i-1];
        win_addr[i]  <= win_addr[i-1];
      end
      win_bytes[0] <= data_byte;
      win_addr[0]  <= byte_address;
    end
  end

`ifndef SYNTH
  a_accept_pending: assert property (@(posedge clk) disable iff (rst)
    accept |=> pending)
    else $error("accepted byte not pending for compare");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= PATTERN_MAX)
    else $error("window fill exceeds depth");
  a_held_window: assert property (@(posedge clk) disable iff (rst)
    scan_stall |=> pending && $stable(fill))
    else $error("window moved while compare stage blocked");
`endif

endmodule

FILE: rtl/mbps_match.sv
// Parallel masked compare over the window and the match result register.
// Depends on mbps_pkg.
module mbps_match #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mbps_pkg::win_stat_t                   stat,
  input  logic [PATTERN_MAX-1:0][7:0]           win_bytes,
  input  logic [PATTERN_MAX-1:0][mbps_pkg::ADDR_W-1:0] win_addr,
  input  logic [PATTERN_MAX-1:0][7:0]           aln_pat,
  input  logic [PATTERN_MAX-1:0]                aln_care,
  input  logic [mbps_pkg::LEN_W-1:0]            len_m1,
  output logic                                  advance,
  output logic                                  match_valid,
  input  logic                                  match_stall,
  output logic [mbps_pkg::ADDR_W-1:0]           match_address
);
  import mbps_pkg::*;

  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic          hit;
  logic          out_free;
  logic [IW-1:0] tap;

  assign tap = len_m1[IW-1:0];

  always_comb begin
    hit = stat.armed;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (aln_care[j] && (win_bytes[j] != aln_pat[j])) begin
        hit = 1'b0;
      end
    end
  end

  assign out_free = !match_valid || !match_stall;
  assign advance  = stat.pending && (!hit || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (advance && hit) begin
      match_valid <= 1'b1;
    end else if (!match_stall) begin
      match_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      match_address <= win_addr[tap];
    end
  end

`ifndef SYNTH
  a_adv_needs_item: assert property (@(posedge clk) disable iff (rst)
    advance |-> stat.pending)
    else $error("compare advanced with no item");
  a_miss_never_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.pending && !hit |-> advance)
    else $error("non-matching byte held the window");
  a_hit_reported: assert property (@(posedge clk) disable iff (rst)
    advance && hit |=> match_valid)
    else $error("match lost");
`endif

endmodule

FILE: rtl/masked_byte_pattern_scanner_core.sv
// Top level of the masked byte pattern scanner.
// Depends on mbps_pkg, mbps_regs, mbps_window and mbps_match.
//
// Usage:
//   Scan channel (scan_valid/scan_stall): one byte of memory per transfer with
//   its byte_address; region_last marks the last byte of a region, after which
//   the window empties so no match spans two regions.
//   Match channel (match_valid/match_stall): one transfer per hit, carrying the
//   address of the matched pattern's first byte. Overlapping hits are all sent.
//   Config: APB-style, 64-bit registers at 8-byte spacing (pattern words 0..3,
//   compare mask, pattern length). Write only while the scanner is idle.
// Timing:
//   One byte per cycle sustained unless a hit waits on a stalled match channel.
//   A taken byte shifts into the window register; the full window is compared
//   in parallel and a hit goes to the result register: the two pipeline stages.
//   Config passes through its registers and then the registered alignment.
// Reset: window emptied, fill count zero, registers to defaults (length 1).
// Stall: a stalled match holds its result register; the scanner keeps taking
//   bytes until another hit arrives, then stalls the scan channel.
module masked_byte_pattern_scanner_core #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            scan_valid,
  output logic                            scan_stall,
  input  logic [7:0]                      data_byte,
  input  logic [mbps_pkg::ADDR_W-1:0]     byte_address,
  input  logic                            region_last,
  output logic                            match_valid,
  input  logic                            match_stall,
  output logic [mbps_pkg::ADDR_W-1:0]     match_address
);
  import mbps_pkg::*;

  // Pattern and care bits pre-aligned to window taps (tap 0 = newest byte).
  logic [PATTERN_MAX-1:0][7:0]        aln_pat;
  logic [PATTERN_MAX-1:0]             aln_care;
  logic [LEN_W-1:0]                   len_m1;
  // Window contents; these registers are the first pipeline stage.
  logic [PATTERN_MAX-1:0][7:0]        win_bytes;
  logic [PATTERN_MAX-1:0][ADDR_W-1:0] win_addr;
  win_stat_t                          stat;
  logic                               advance;   // compare stage consumes newest byte

  mbps_regs #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .aln_pat  (aln_pat),
    .aln_care (aln_care),
    .len_m1   (len_m1)
  );

  mbps_window #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .scan_valid   (scan_valid),
    .scan_stall   (scan_stall),
    .data_byte    (data_byte),
    .byte_address (byte_address),
    .region_last  (region_last),
    .len_m1       (len_m1),
    .advance      (advance),
    .win_bytes    (win_bytes),
    .win_addr     (win_addr),
    .stat         (stat)
  );

  mbps_match #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_match (
    .clk           (clk),
    .rst           (rst),
    .stat          (stat),
    .win_bytes     (win_bytes),
    .win_addr      (win_addr),
    .aln_pat       (aln_pat),
    .aln_care      (aln_care),
    .len_m1        (len_m1),
    .advance       (advance),
    .match_valid   (match_valid),
    .match_stall   (match_stall),
    .match_address (match_address)
  );

endmodule
